[hdl/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon crossing-number block.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MaxVerticesDef = 64;
  localparam int CoordWidthDef  = 16;
  localparam int TotalWidth     = 7;
  localparam int KindWidth      = 2;

  typedef enum logic [KindWidth-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEST   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_WAIT,
    ST_EDGE,
    ST_DIV,
    ST_CMP,
    ST_NEXT,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_item;   // latch the input item
    logic do_clear;
    logic do_append;
    logic rd_start;    // address the last vertex, restart at vertex 0
    logic load_edge;   // capture vertex i, start edge evaluation
    logic div_start;
    logic do_cmp;      // compare px with the crossing x, flip parity if greater
    logic rd_next;     // step to next vertex
    logic load_out;    // load result register
  } pip_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_test;
    logic is_empty;
    logic spans;
    logic div_done;
    logic last_edge;
  } pip_sts_t;

endpackage

[hdl/pip_if.sv]
// ----------------------------------------------------------------------------
// pip_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface pip_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/pip_ram.sv]
// ----------------------------------------------------------------------------
// pip_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[hdl/pip_div.sv]
// ----------------------------------------------------------------------------
// pip_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero.
// ----------------------------------------------------------------------------
module pip_div #(
  parameter int NumWidth = 34,
  parameter int DenWidth = 17
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [NumWidth-1:0] num,
  input  logic signed [DenWidth-1:0] den,
  output logic                       done,
  output logic signed [NumWidth-1:0] quot
);
  localparam int CntWidth = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] q_r, q_nxt;
  logic [DenWidth:0]   rem_r, rem_nxt;
  logic [DenWidth-1:0] dmag_r, dmag_nxt;
  logic                neg_r, neg_nxt;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic [DenWidth:0]   trial;
  logic [DenWidth:0]   shifted;

  // restoring step
  always_comb begin
    shifted  = {rem_r[DenWidth-1:0], q_r[NumWidth-1]};
    trial    = shifted - {1'b0, dmag_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = num[NumWidth-1] ? NumWidth'(-num) : num;
      dmag_nxt = den[DenWidth-1] ? DenWidth'(-den) : den;
      neg_nxt  = num[NumWidth-1] ^ den[DenWidth-1];
      rem_nxt  = '0;
      cnt_nxt  = CntWidth'(NumWidth);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DenWidth]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[NumWidth-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[NumWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntWidth'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
  end

  assign done = !busy_r && !start;
  assign quot = neg_r ? NumWidth'(-q_r) : q_r;
endmodule

[hdl/pip_datapath.sv]
// ----------------------------------------------------------------------------
// pip_datapath
// Vertex store, edge arithmetic, divider, parity and result register.
// ----------------------------------------------------------------------------
module pip_datapath #(
  parameter int MaxVertices = pip_pkg::MaxVerticesDef,
  parameter int CoordWidth  = pip_pkg::CoordWidthDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pip_pkg::pip_cmd_t       cmd,
  output pip_pkg::pip_sts_t       sts,
  input  logic [1:0]              in_kind,
  input  logic signed [CoordWidth-1:0] in_x,
  input  logic signed [CoordWidth-1:0] in_y,
  output logic                    res_inside,
  output logic [pip_pkg::TotalWidth-1:0] res_total,
  output logic                    res_dropped
);
  localparam int AddrWidth = $clog2(MaxVertices);
  localparam int CntWidth  = $clog2(MaxVertices + 1);
  localparam int DiffWidth = CoordWidth + 1;
  localparam int ProdWidth = 2 * DiffWidth;
  localparam int NumWidth  = ProdWidth;
  localparam int SumWidth  = NumWidth + 1;

  logic [1:0]                  kind_r;
  logic signed [CoordWidth-1:0] px_r, py_r;
  logic [CntWidth-1:0]         count_r, count_nxt;
  logic [CntWidth-1:0]         idx_r, idx_nxt;
  logic [AddrWidth-1:0]        addr;
  logic                        we;
  logic [2*CoordWidth-1:0]     wdata, rdata;
  logic signed [CoordWidth-1:0] xi_r, yi_r, xj_r, yj_r;
  logic signed [ProdWidth-1:0] prod_r;
  logic signed [DiffWidth-1:0] dy_r;
  logic                        parity_r;
  logic                        dropped_r;
  logic                        jload_r;
  logic                        div_done;
  logic signed [NumWidth-1:0]  quot;
  logic signed [SumWidth-1:0]  edge_x;
  logic signed [CoordWidth-1:0] rx, ry;
  logic signed [DiffWidth-1:0] dxji, dyp, dyji;

  assign rx = rdata[2*CoordWidth-1:CoordWidth];
  assign ry = rdata[CoordWidth-1:0];

  // store port: writes on append while not full, reads walk the vertices
  assign we    = cmd.do_append && (count_r < CntWidth'(MaxVertices));
  assign wdata = {in_x, in_y};
  always_comb begin
    if (cmd.do_append) begin
      addr = count_r[AddrWidth-1:0];
    end else if (cmd.rd_start) begin
      addr = AddrWidth'(count_r - 1'b1);
    end else begin
      addr = idx_r[AddrWidth-1:0];
    end
  end

  pip_ram #(.Width(2 * CoordWidth), .Depth(MaxVertices)) u_store (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // vertex count
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_clear) begin
      count_nxt = '0;
    end else if (we) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // edge index
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.rd_start) begin
      idx_nxt = '0;
    end else if (cmd.rd_next) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // edge differences taken against vertex i as it leaves the store, so the
  // registered product is ready on the first divide cycle
  assign dxji = DiffWidth'(xj_r) - DiffWidth'(rx);
  assign dyp  = DiffWidth'(py_r) - DiffWidth'(ry);
  assign dyji = DiffWidth'(yj_r) - DiffWidth'(ry);

  pip_div #(.NumWidth(NumWidth), .DenWidth(DiffWidth)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (dy_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign edge_x = SumWidth'(quot) + SumWidth'(xi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      parity_r <= 1'b0;
      jload_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      jload_r <= cmd.rd_start;
      if (cmd.rd_start) begin
        parity_r <= 1'b0;
      end else if (cmd.do_cmp && (SumWidth'(px_r) > edge_x)) begin
        parity_r <= ~parity_r;
      end
    end
    idx_r <= idx_nxt;
    if (cmd.take_item) begin
      kind_r <= in_kind;
      px_r   <= in_x;
      py_r   <= in_y;
    end
    dropped_r <= cmd.do_append ? !we : (cmd.take_item ? 1'b0 : dropped_r);
    // vertex i as it arrives from the store
    if (cmd.load_edge) begin
      xi_r <= rx;
      yi_r <= ry;
    end
    // first read returns the last vertex, which is j for edge 0
    if (jload_r) begin
      xj_r <= rx;
      yj_r <= ry;
    end else if (cmd.rd_next) begin
      xj_r <= xi_r;
      yj_r <= yi_r;
    end
    prod_r <= dxji * dyp;
    dy_r   <= dyji;
    if (cmd.load_out) begin
      res_inside <= (kind_r == pip_pkg::KIND_TEST) ? parity_r : 1'b0;
      res_total  <= pip_pkg::TotalWidth'(count_r);
      res_dropped <= dropped_r;
    end
  end

  assign sts.is_test   = (kind_r == pip_pkg::KIND_TEST);
  assign sts.is_empty  = (count_r == '0);
  assign sts.spans     = ((yi_r < py_r) && (py_r <= yj_r)) ||
                         ((yj_r < py_r) && (py_r <= yi_r));
  assign sts.div_done  = div_done;
  assign sts.last_edge = (idx_r == CntWidth'(count_r - 1'b1));
endmodule

[hdl/pip_ctrl.sv]
// ----------------------------------------------------------------------------
// pip_ctrl
// Sequencer: one item at a time, walks the edges of a query.
// ----------------------------------------------------------------------------
module pip_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  output logic              out_valid,
  input  logic              out_ready,
  output pip_pkg::pip_cmd_t cmd,
  input  pip_pkg::pip_sts_t sts
);
  pip_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  // a new item is taken when idle and the result slot is free or leaving
  assign in_ready  = (state_r == pip_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pip_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_kind == pip_pkg::KIND_TEST) ? pip_pkg::ST_RD_FIRST
                                                      : pip_pkg::ST_OUT;
        end
      end
      pip_pkg::ST_RD_FIRST: begin
        state_nxt = sts.is_empty ? pip_pkg::ST_OUT : pip_pkg::ST_RD_WAIT;
      end
      pip_pkg::ST_RD_WAIT: state_nxt = pip_pkg::ST_EDGE;
      pip_pkg::ST_EDGE: begin
        state_nxt = pip_pkg::ST_DIV;
      end
      pip_pkg::ST_DIV: begin
        if (!sts.spans) begin
          state_nxt = pip_pkg::ST_NEXT;
        end else if (sts.div_done) begin
          state_nxt = pip_pkg::ST_CMP;
        end
      end
      pip_pkg::ST_CMP:  state_nxt = pip_pkg::ST_NEXT;
      pip_pkg::ST_NEXT: begin
        state_nxt = sts.last_edge ? pip_pkg::ST_OUT : pip_pkg::ST_RD_WAIT;
      end
      pip_pkg::ST_OUT:  state_nxt = pip_pkg::ST_IDLE;
      default:          state_nxt = pip_pkg::ST_IDLE;
    endcase
  end

  // outputs
  logic div_started_r;
  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      pip_pkg::ST_IDLE: begin
        cmd.take_item = accept;
        cmd.do_clear  = accept && (in_kind == pip_pkg::KIND_CLEAR);
        cmd.do_append = accept && (in_kind == pip_pkg::KIND_APPEND);
      end
      pip_pkg::ST_RD_FIRST: cmd.rd_start = 1'b1;
      pip_pkg::ST_EDGE:     cmd.load_edge = 1'b1;
      pip_pkg::ST_RD_WAIT:  cmd.load_edge = 1'b0;
      pip_pkg::ST_DIV:      cmd.div_start = sts.spans && !div_started_r;
      pip_pkg::ST_CMP:      cmd.do_cmp = 1'b1;
      pip_pkg::ST_NEXT:     cmd.rd_next = 1'b1;
      pip_pkg::ST_OUT: begin
        cmd.load_out  = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pip_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      div_started_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      div_started_r <= (state_r == pip_pkg::ST_DIV) && state_nxt == pip_pkg::ST_DIV;
    end
  end
endmodule

[hdl/point_in_polygon_test.sv]
// operation: clear/append go straight to the result; a query walks the edges
//   of the n stored vertices, none when empty (a spanning edge waits on the
//   divider, one quotient bit per cycle, 34 bits at 16 bits; others skip it)
// throughput: one item at a time; next item taken as the result is taken
// reset: synchronous active-low rst_n empties the vertex count and result slot
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Crossing-number point-in-polygon test over a stored vertex list.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
  parameter int MaxVertices = pip_pkg::MaxVerticesDef,
  parameter int CoordWidth  = pip_pkg::CoordWidthDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [CoordWidth-1:0] in_coord_x,
  input  logic [CoordWidth-1:0] in_coord_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_inside_res,
  output logic [6:0]           out_vertex_total,
  output logic                 out_dropped
);
  pip_pkg::pip_cmd_t cmd;
  pip_pkg::pip_sts_t sts;

  pip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pip_datapath #(.MaxVertices(MaxVertices), .CoordWidth(CoordWidth)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_kind     (in_kind),
    .in_x        (in_coord_x),
    .in_y        (in_coord_y),
    .res_inside  (out_inside_res),
    .res_total   (out_vertex_total),
    .res_dropped (out_dropped)
  );
endmodule

[hdl/pip_checker.sv]
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks for the point-in-polygon block.
// ----------------------------------------------------------------------------
module pip_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_inside_res,
  input logic [6:0] out_vertex_total,
  input logic       out_dropped
);
  // result valid and vertex total held while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_total))
    else $error("result dropped under stall");

  // a clear always reports an empty store
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == pip_pkg::KIND_CLEAR |=> ##1 out_vertex_total == 7'd0)
    else $error("clear left vertices");

  // an empty polygon is never inside
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_vertex_total == 7'd0 |-> !out_inside_res)
    else $error("inside with empty polygon");

  // drop and inside never together
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_dropped && out_inside_res))
    else $error("drop on a query");
endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);

[tb/point_in_polygon_test_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_tb
// Drives clear, append, test and unused requests into the polygon block with
// random gaps and output stalls. A behavioural crossing-number model predicts
// every result, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb;

  localparam int CW         = pip_pkg::CoordWidthDef;
  localparam int MaxVerts   = pip_pkg::MaxVerticesDef;
  localparam int StallLimit = 20000;

  typedef struct packed {
    pip_pkg::kind_t  kind;
    logic [CW-1:0]   coord_x;
    logic [CW-1:0]   coord_y;
  } poly_req_t;

  typedef struct packed {
    logic            inside_res;
    logic [6:0]      vertex_total;
    logic            dropped;
  } poly_res_t;

  logic clk;
  logic rst_n;

  pip_if #(.payload_t(poly_req_t)) req_ch ();
  pip_if #(.payload_t(poly_res_t)) res_ch ();

  point_in_polygon_test uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (req_ch.valid),
    .in_ready         (req_ch.ready),
    .in_kind          (req_ch.data.kind),
    .in_coord_x       (req_ch.data.coord_x),
    .in_coord_y       (req_ch.data.coord_y),
    .out_valid        (res_ch.valid),
    .out_ready        (res_ch.ready),
    .out_inside_res   (res_ch.data.inside_res),
    .out_vertex_total (res_ch.data.vertex_total),
    .out_dropped      (res_ch.data.dropped)
  );

  // polygon model state
  logic signed [CW-1:0] poly_x [MaxVerts];
  logic signed [CW-1:0] poly_y [MaxVerts];
  int                   poly_count;

  poly_res_t expected_results[$];
  int        mismatch_count;
  int        idle_cycles;
  bit        no_gaps;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // crossing-number parity over the modelled vertex list
  function automatic logic crossing_parity(logic signed [CW-1:0] px,
                                           logic signed [CW-1:0] py);
    logic   parity;
    int     j;
    longint xi, yi, xj, yj, q;
    parity = 1'b0;
    j = poly_count - 1;
    for (int i = 0; i < poly_count; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if (((yi < py && py <= yj) || (yj < py && py <= yi)) && yj != yi) begin
        q = ((xj - xi) * (longint'(py) - yi)) / (yj - yi);
        if (longint'(px) > q + xi) parity = ~parity;
      end
      j = i;
    end
    return parity;
  endfunction

  // update model state and return the result a request causes
  function automatic poly_res_t predict_polygon_result(poly_req_t req);
    poly_res_t res;
    res = '0;
    case (req.kind)
      pip_pkg::KIND_CLEAR: begin
        poly_count = 0;
      end
      pip_pkg::KIND_APPEND: begin
        if (poly_count < MaxVerts) begin
          poly_x[poly_count] = req.coord_x;
          poly_y[poly_count] = req.coord_y;
          poly_count++;
        end else begin
          res.dropped = 1'b1;
        end
      end
      pip_pkg::KIND_TEST: begin
        res.inside_res = crossing_parity(req.coord_x, req.coord_y);
      end
      default: ;
    endcase
    res.vertex_total = 7'(poly_count);
    return res;
  endfunction

  // send one request, predicting its result when it is taken
  task automatic send_request(pip_pkg::kind_t kind, int x, int y);
    int        gap;
    poly_req_t req;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.kind    = kind;
    req.coord_x = CW'(x);
    req.coord_y = CW'(y);
    req_ch.valid <= 1'b1;
    req_ch.data  <= req;
    do @(posedge clk); while (!req_ch.ready);
    expected_results.push_back(predict_polygon_result(req));
  endtask

  function automatic int rand_coord(bit narrow);
    if (narrow) return $urandom_range(0, 40) - 20;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  // result side stalls
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // result checker
  always @(posedge clk) begin
    poly_res_t exp_res;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: %p", res_ch.data);
      end else begin
        exp_res = expected_results.pop_front();
        if (res_ch.data.inside_res !== exp_res.inside_res ||
            res_ch.data.vertex_total !== exp_res.vertex_total ||
            res_ch.data.dropped !== exp_res.dropped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: expected inside %0b total %0d dropped %0b,",
                      " got %0b %0d %0b"},
                     exp_res.inside_res, exp_res.vertex_total, exp_res.dropped,
                     res_ch.data.inside_res, res_ch.data.vertex_total,
                     res_ch.data.dropped);
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // extremes, empty and small polygons, unused kind, horizontal edges
  task automatic test_directed();
    send_request(pip_pkg::KIND_TEST, 0, 0);
    send_request(pip_pkg::KIND_CLEAR, 32767, -32768);
    send_request(pip_pkg::KIND_APPEND, 5, 5);
    send_request(pip_pkg::KIND_TEST, 0, 5);
    send_request(pip_pkg::KIND_APPEND, -5, -5);
    send_request(pip_pkg::KIND_TEST, 0, 0);
    send_request(pip_pkg::KIND_CLEAR, 0, 0);
    send_request(pip_pkg::KIND_APPEND, -10, -10);
    send_request(pip_pkg::KIND_APPEND, 10, -10);
    send_request(pip_pkg::KIND_APPEND, 10, 10);
    send_request(pip_pkg::KIND_APPEND, -10, 10);
    send_request(pip_pkg::KIND_TEST, 0, 0);
    send_request(pip_pkg::KIND_TEST, 10, 0);
    send_request(pip_pkg::KIND_TEST, -10, 0);
    send_request(pip_pkg::KIND_TEST, 0, 10);
    send_request(pip_pkg::KIND_TEST, 0, -10);
    send_request(pip_pkg::KIND_TEST, 11, 3);
    send_request(pip_pkg::KIND_NONE, -1, -1);
    send_request(pip_pkg::KIND_CLEAR, -1, -1);
    send_request(pip_pkg::KIND_APPEND, -32768, -32768);
    send_request(pip_pkg::KIND_APPEND, 32767, -32768);
    send_request(pip_pkg::KIND_APPEND, 0, 32767);
    send_request(pip_pkg::KIND_TEST, 0, 0);
    send_request(pip_pkg::KIND_TEST, 32767, 32767);
    send_request(pip_pkg::KIND_TEST, -32768, -32767);
  endtask

  // fill the store, overflow it, query the full polygon
  task automatic test_full_store();
    send_request(pip_pkg::KIND_CLEAR, 0, 0);
    for (int k = 0; k < MaxVerts; k++)
      send_request(pip_pkg::KIND_APPEND, rand_coord(k % 2), rand_coord(k % 3 == 0));
    send_request(pip_pkg::KIND_APPEND, 1, 1);
    send_request(pip_pkg::KIND_APPEND, -32768, 32767);
    for (int k = 0; k < 4; k++)
      send_request(pip_pkg::KIND_TEST, rand_coord(k % 2), rand_coord(k % 2));
  endtask

  // random polygons with queries, plus noise
  task automatic test_random_polygons();
    int  sent;
    int  nverts;
    bit  narrow;
    sent = 0;
    while (sent < 150) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      narrow  = $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) begin
        send_request(pip_pkg::kind_t'($urandom_range(0, 3)), rand_coord(0), rand_coord(0));
        sent++;
      end else begin
        send_request(pip_pkg::KIND_CLEAR, rand_coord(0), rand_coord(0));
        nverts = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 10);
        for (int k = 0; k < nverts; k++)
          send_request(pip_pkg::KIND_APPEND, rand_coord(narrow), rand_coord(narrow));
        for (int k = $urandom_range(2, 6); k > 0; k--)
          send_request(pip_pkg::KIND_TEST, rand_coord(narrow), rand_coord(narrow));
        sent += nverts + 4;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.data    <= '0;
    mismatch_count  = 0;
    poly_count      = 0;
    no_gaps         = 1'b0;
    idle_cycles     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_store();
    test_random_polygons();

    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
